/* hw/rtl/nibble_delta_table_decoder_unit_macros.svh */
// Assertion macros shared by the decoder modules.
`ifndef NIBBLE_DELTA_TABLE_DECODER_UNIT_MACROS_SVH
`define NIBBLE_DELTA_TABLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define NDTD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ndtd: same-cycle check failed");

// Next-cycle implication.
`define NDTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ndtd: next-cycle check failed");

`endif

/* hw/rtl/ndtd_pkg.sv */
package ndtd_pkg;

  localparam int NDTD_QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DECODE = 2'd1;
  localparam logic [1:0] FUNC_SKIP   = 2'd2;

  localparam logic [3:0] STEP_CODE_MAX = 4'd14;

  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = -16'sh8000;

  typedef logic signed [14:0] step_t;
  typedef logic signed [15:0] sum_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DECODE = 2'd1,
    OP_SKIP   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] start_value;
    step_t              step_hi;
    step_t              step_lo;
    sum_t               step_sum;
    logic               block_end;
  } cmd_t;

  localparam step_t STEP_TABLE [15] = '{
    -15'sd8192, -15'sd4096, -15'sd2048, -15'sd1024, -15'sd512, -15'sd256, -15'sd64,
    15'sd0, 15'sd64, 15'sd256, 15'sd512, 15'sd1024, 15'sd2048, 15'sd4096, 15'sd8192
  };

  function automatic step_t step_of(input logic [3:0] code);
    logic [3:0] clamped;
    clamped = (code > STEP_CODE_MAX) ? STEP_CODE_MAX : code;
    return STEP_TABLE[clamped];
  endfunction

endpackage

/* hw/rtl/ndtd_if.sv */
interface ndtd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] start_value;
  logic [7:0]         code_byte;
  logic               block_end;

  modport source (output valid, func, start_value, code_byte, block_end, input ready);
  modport sink (input valid, func, start_value, code_byte, block_end, output ready);
endinterface

interface ndtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic signed [31:0] running_total;
  logic               is_sample;
  logic               last;

  modport source (output valid, sample, running_total, is_sample, last, input ready);
  modport sink (input valid, sample, running_total, is_sample, last, output ready);
endinterface

/* hw/rtl/ndtd_front.sv */
module ndtd_front (
  ndtd_in_if.sink         request,
  input  logic            full,
  output logic            push,
  output ndtd_pkg::cmd_t  cmd
);
  import ndtd_pkg::*;

  step_t hi;
  step_t lo;
  logic  keep;

  always_comb begin
    hi = step_of(request.code_byte[7:4]);
    lo = step_of(request.code_byte[3:0]);
    cmd.op = OP_LOAD;
    keep = 1'b0;
    unique case (request.func)
      FUNC_LOAD: begin
        cmd.op = OP_LOAD;
        keep = 1'b1;
      end
      FUNC_DECODE: begin
        cmd.op = OP_DECODE;
        keep = 1'b1;
      end
      FUNC_SKIP: begin
        cmd.op = OP_SKIP;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    cmd.start_value = request.start_value;
    cmd.step_hi = hi;
    cmd.step_lo = lo;
    cmd.step_sum = sum_t'(hi) + sum_t'(lo);
    cmd.block_end = request.block_end;
  end

  // drop unused function codes at the door
  assign request.ready = !full;
  assign push = request.valid && !full && keep;

endmodule

/* hw/rtl/ndtd_queue.sv */
`include "nibble_delta_table_decoder_unit_macros.svh"

module ndtd_queue #(
  parameter int Depth = ndtd_pkg::NDTD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ndtd_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ndtd_pkg::cmd_t  head
);
  import ndtd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  `NDTD_ASSERT_IMPL(a_push_not_full, clk, rst, push, !full)
  `NDTD_ASSERT_IMPL(a_pop_not_empty, clk, rst, pop, head_valid)
  `NDTD_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* hw/rtl/ndtd_back.sv */
`include "nibble_delta_table_decoder_unit_macros.svh"

module ndtd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ndtd_pkg::cmd_t  head,
  output logic            pop,
  ndtd_out_if.source      result
);
  import ndtd_pkg::*;

  logic signed [31:0] acc;
  logic               phase;
  logic               phase_next;
  logic               out_valid;
  logic signed [15:0] out_sample;
  logic signed [31:0] out_total;
  logic               out_is_sample;
  logic               out_last;

  logic               out_free;
  logic               emit;
  logic               acc_en;
  logic               load_en;
  logic               is_skip;
  sum_t               step_sel;
  logic signed [31:0] acc_next;
  logic signed [15:0] sat;

  assign out_free = !out_valid || result.ready;
  assign is_skip = (head.op == OP_SKIP);

  always_comb begin
    if (is_skip) begin
      step_sel = head.step_sum;
    end else if (phase) begin
      step_sel = sum_t'(head.step_lo);
    end else begin
      step_sel = sum_t'(head.step_hi);
    end
    acc_next = acc + 32'(step_sel);
    if ((&acc_next[31:15]) || !(|acc_next[31:15])) begin
      sat = acc_next[15:0];
    end else begin
      sat = acc_next[31] ? SAT_MIN : SAT_MAX;
    end
  end

  always_comb begin
    pop = 1'b0;
    emit = 1'b0;
    acc_en = 1'b0;
    load_en = 1'b0;
    phase_next = phase;
    if (head_valid) begin
      unique case (head.op)
        OP_LOAD: begin
          pop = 1'b1;
          load_en = 1'b1;
        end
        OP_DECODE: begin
          if (out_free) begin
            emit = 1'b1;
            acc_en = 1'b1;
            if (phase) begin
              pop = 1'b1;
              phase_next = 1'b0;
            end else begin
              phase_next = 1'b1;
            end
          end
        end
        OP_SKIP: begin
          if (!head.block_end || out_free) begin
            pop = 1'b1;
            acc_en = 1'b1;
            emit = head.block_end;
          end
        end
        default: begin
          pop = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_en) begin
        acc <= head.start_value;
      end else if (acc_en) begin
        acc <= acc_next;
      end
      phase <= phase_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= is_skip ? '0 : sat;
      out_total <= acc_next;
      out_is_sample <= !is_skip;
      out_last <= is_skip || (phase && head.block_end);
    end
  end

  assign result.valid = out_valid;
  assign result.sample = out_sample;
  assign result.running_total = out_total;
  assign result.is_sample = out_is_sample;
  assign result.last = out_last;

  `NDTD_ASSERT_IMPL(a_phase_on_decode, clk, rst, phase, head_valid && head.op == OP_DECODE)
  `NDTD_ASSERT_IMPL(a_report_shape, clk, rst, out_valid && !out_is_sample,
                    out_last && out_sample == '0)
  `NDTD_ASSERT_IMPL(a_emit_has_room, clk, rst, emit, out_free && head_valid)

endmodule

/* hw/rtl/nibble_delta_table_decoder_unit.sv */
// Timing: a request sits at the queue head in the cycle after acceptance (empty queue); its
// first result, if any, is loaded into the output register as soon as that register is free.
// Flow: decode gives two samples per request, hi then lo, one sample per cycle while the
// single output register is free; load pops at once; unused codes are dropped at input.
// Reset: synchronous rst clears the accumulator, the queue and the output valid.
module nibble_delta_table_decoder_unit #(
  parameter int QueueDepth = ndtd_pkg::NDTD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  ndtd_in_if.sink     request,
  ndtd_out_if.source  result
);
  import ndtd_pkg::*;

  cmd_t front_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  ndtd_front u_front (
    .request (request),
    .full    (full),
    .push    (push),
    .cmd     (front_cmd)
  );

  ndtd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (front_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ndtd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule
